FILE: hdl/qoi_pixel_encoder_macros.svh
// Assertion helpers shared by the encoder modules.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef QOI_PIXEL_ENCODER_MACROS_SVH
`define QOI_PIXEL_ENCODER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define QOIENC_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define QOIENC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/qoienc_pkg.sv
package qoienc_pkg;

  // Colour index geometry and run limit of the stream format.
  localparam int unsigned INDEX_ENTRIES = 64;
  localparam int unsigned HASH_W        = $clog2(INDEX_ENTRIES);
  localparam int unsigned RUN_W         = 6;
  localparam logic [RUN_W-1:0] MAX_RUN  = 6'd62;

  // Up to six bytes may follow from one pixel: a run flush and a five-byte RGBA op.
  localparam int unsigned CMD_BYTES = 6;
  localparam int unsigned CMD_CNT_W = $clog2(CMD_BYTES + 1);
  localparam int unsigned OP_BYTES  = 5;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Op codes of the byte stream.
  localparam logic [7:0] OP_INDEX    = 8'h00;
  localparam logic [7:0] OP_DIFF     = 8'h40;
  localparam logic [7:0] OP_LUMA     = 8'h80;
  localparam logic [7:0] OP_RUN      = 8'hc0;
  localparam logic [7:0] OP_RGB      = 8'hfe;
  localparam logic [7:0] OP_RGBA     = 8'hff;
  localparam logic [7:0] OP_RUN_FULL = 8'hfd;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CH_W       = 3;
  localparam logic [0:0] REG_IDX_CHANNEL_COUNT = 1'b0;
  localparam logic [CH_W-1:0] CH_RGB  = 3'd3;
  localparam logic [CH_W-1:0] CH_RGBA = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  localparam pixel_t PIXEL_RESET = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'hff};

  // One queue entry: the bytes caused by one pixel, first byte in element zero.
  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [CMD_CNT_W-1:0]      count;
  } cmd_t;

  // Index hash r*3 + g*5 + b*7 + a*11, modulo the table size.
  function automatic logic [HASH_W-1:0] color_hash(input pixel_t p);
    logic [HASH_W-1:0] hr;
    logic [HASH_W-1:0] hg;
    logic [HASH_W-1:0] hb;
    logic [HASH_W-1:0] ha;
    hr = HASH_W'(p.red * 3);
    hg = HASH_W'(p.green * 5);
    hb = HASH_W'(p.blue * 7);
    ha = HASH_W'(p.alpha * 11);
    return HASH_W'(hr + hg + hb + ha);
  endfunction

endpackage

FILE: hdl/qoienc_pix_if.sv
interface qoienc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output last_pixel, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input last_pixel, output ready);
endinterface

FILE: hdl/qoienc_byte_if.sv
interface qoienc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_of_pixel;

  modport source (output valid, output code_byte, output last_of_pixel, input ready);
  modport sink (input valid, input code_byte, input last_of_pixel, output ready);
endinterface

FILE: hdl/qoienc_front.sv
`include "qoi_pixel_encoder_macros.svh"

module qoienc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [qoienc_pkg::CH_W-1:0] channel_count,
  qoienc_pix_if.sink                  pix,
  output qoienc_pkg::cmd_t            cmd,
  output logic                        cmd_valid,
  input  logic                        cmd_ready
);
  import qoienc_pkg::*;

  pixel_t            in_px;
  logic [HASH_W-1:0] in_hash;
  logic              take;

  logic              s1_valid_r;
  pixel_t            s1_px_r;
  logic              s1_last_r;
  logic [HASH_W-1:0] s1_hash_r;
  logic              s1_go;

  pixel_t                   idx_mem [INDEX_ENTRIES];
  logic [INDEX_ENTRIES-1:0] ent_vld_r;
  pixel_t                   ent_q_r;
  logic                     ent_ok_r;
  logic                     wr_en;

  pixel_t           prev_r;
  logic [RUN_W-1:0] run_r;
  logic [RUN_W-1:0] run_nxt;
  logic [RUN_W-1:0] run_inc;

  logic eq_prev;
  logic hit;
  logic [7:0] dr, dg, db, dgr, dgb;
  logic [7:0] ddr, ddg, ddb, lg, lrg, lbg;
  logic is_diff;
  logic is_luma;
  logic [OP_BYTES-1:0][7:0] ob;
  logic [CMD_CNT_W-1:0]     op_len;

  // Three-channel mode replaces the incoming alpha before anything sees it.
  always_comb begin
    in_px.red   = pix.red;
    in_px.green = pix.green;
    in_px.blue  = pix.blue;
    in_px.alpha = (channel_count == CH_RGB) ? 8'hff : pix.alpha;
  end

  assign in_hash   = color_hash(in_px);
  assign pix.ready = !s1_valid_r || s1_go;
  assign take      = pix.valid && pix.ready;

  assign cmd_valid = s1_valid_r && (cmd.count != '0);
  assign s1_go     = s1_valid_r && ((cmd.count == '0) || cmd_ready);

  // A new colour (no repeat, no hit) is written when it leaves the stage, at the same edge
  // at which the next pixel's entry is read, so a matching address is bypassed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      idx_mem[s1_hash_r] <= s1_px_r;
    end
    if (take) begin
      if (wr_en && (s1_hash_r == in_hash)) begin
        ent_q_r <= s1_px_r;
      end else begin
        ent_q_r <= idx_mem[in_hash];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      ent_ok_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_r[s1_hash_r] <= 1'b1;
      end
      if (take) begin
        ent_ok_r <= (wr_en && (s1_hash_r == in_hash)) || ent_vld_r[in_hash];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_px_r   <= in_px;
      s1_last_r <= pix.last_pixel;
      s1_hash_r <= in_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      prev_r     <= PIXEL_RESET;
      run_r      <= '0;
    end else begin
      if (pix.ready) begin
        s1_valid_r <= pix.valid;
      end
      if (s1_go) begin
        prev_r <= s1_px_r;
        run_r  <= run_nxt;
      end
    end
  end

  // Classification of the pixel held in the stage.
  always_comb begin
    eq_prev = (s1_px_r == prev_r);
    hit     = ent_ok_r ? (ent_q_r == s1_px_r) : (s1_px_r == '0);
    wr_en   = s1_go && !eq_prev && !hit;

    dr  = s1_px_r.red - prev_r.red;
    dg  = s1_px_r.green - prev_r.green;
    db  = s1_px_r.blue - prev_r.blue;
    dgr = dr - dg;
    dgb = db - dg;

    // Biasing each difference turns the signed range checks into unsigned ones.
    ddr = dr + 8'd2;
    ddg = dg + 8'd2;
    ddb = db + 8'd2;
    lg  = dg + 8'd32;
    lrg = dgr + 8'd8;
    lbg = dgb + 8'd8;
    is_diff = (ddr < 8'd4) && (ddg < 8'd4) && (ddb < 8'd4);
    is_luma = (lg < 8'd64) && (lrg < 8'd16) && (lbg < 8'd16);

    ob     = '0;
    op_len = '0;
    priority if (hit) begin
      ob[0]  = OP_INDEX | {{(8 - HASH_W){1'b0}}, s1_hash_r};
      op_len = CMD_CNT_W'(1);
    end else if (s1_px_r.alpha != prev_r.alpha) begin
      ob[0]  = OP_RGBA;
      ob[1]  = s1_px_r.red;
      ob[2]  = s1_px_r.green;
      ob[3]  = s1_px_r.blue;
      ob[4]  = s1_px_r.alpha;
      op_len = CMD_CNT_W'(5);
    end else if (is_diff) begin
      ob[0]  = OP_DIFF | {2'b00, ddr[1:0], ddg[1:0], ddb[1:0]};
      op_len = CMD_CNT_W'(1);
    end else if (is_luma) begin
      ob[0]  = OP_LUMA | {2'b00, lg[5:0]};
      ob[1]  = {lrg[3:0], lbg[3:0]};
      op_len = CMD_CNT_W'(2);
    end else begin
      ob[0]  = OP_RGB;
      ob[1]  = s1_px_r.red;
      ob[2]  = s1_px_r.green;
      ob[3]  = s1_px_r.blue;
      op_len = CMD_CNT_W'(4);
    end
  end

  // Assembly of the byte list, with the run flush placed in front of the op.
  always_comb begin
    run_inc = run_r + 1'b1;
    run_nxt = run_r;
    cmd     = '0;
    if (eq_prev) begin
      if (run_inc == MAX_RUN) begin
        cmd.bytes[0] = OP_RUN_FULL;
        cmd.count    = CMD_CNT_W'(1);
        run_nxt      = '0;
      end else if (s1_last_r) begin
        cmd.bytes[0] = OP_RUN | {2'b00, run_r};
        cmd.count    = CMD_CNT_W'(1);
        run_nxt      = '0;
      end else begin
        run_nxt = run_inc;
      end
    end else begin
      run_nxt = '0;
      if (run_r != '0) begin
        cmd.bytes[0]   = OP_RUN | {2'b00, run_r - 1'b1};
        cmd.bytes[5:1] = ob;
        cmd.count      = op_len + 1'b1;
      end else begin
        cmd.bytes[4:0] = ob;
        cmd.count      = op_len;
      end
    end
  end

  `QOIENC_CHECK(a_run_below_max, run_r < MAX_RUN, "run count reached the run limit")
  `QOIENC_CHECK_NEXT(a_stage_holds, s1_valid_r && !s1_go, s1_valid_r && $stable(s1_px_r), "stalled pixel lost or changed")

endmodule

FILE: hdl/qoienc_queue.sv
`include "qoi_pixel_encoder_macros.svh"

module qoienc_queue #(
  parameter int unsigned DEPTH = qoienc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  qoienc_pkg::cmd_t wr_cmd,
  input  logic             wr_valid,
  output logic             wr_ready,
  output qoienc_pkg::cmd_t rd_cmd,
  output logic             rd_valid,
  input  logic             rd_pop
);
  import qoienc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_step(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_step(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `QOIENC_CHECK(a_fill_bound, cnt_r <= CNT_W'(DEPTH), "queue fill count beyond its depth")
  `QOIENC_CHECK(a_no_empty_pop, !rd_pop || rd_valid, "entry released from an empty queue")

endmodule

FILE: hdl/qoienc_back.sv
`include "qoi_pixel_encoder_macros.svh"

module qoienc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  qoienc_pkg::cmd_t head,
  input  logic             head_valid,
  output logic             head_pop,
  qoienc_byte_if.source    ob
);
  import qoienc_pkg::*;

  logic [CMD_CNT_W-1:0] pos_r;
  logic                 at_end;
  logic                 xfer;

  assign at_end           = (pos_r == CMD_CNT_W'(head.count - 1'b1));
  assign ob.valid         = head_valid;
  assign ob.code_byte     = head.bytes[pos_r];
  assign ob.last_of_pixel = at_end;
  assign xfer             = ob.valid && ob.ready;
  assign head_pop         = xfer && at_end;

  // Walks through the bytes of the head entry, one per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (xfer) begin
      pos_r <= at_end ? '0 : pos_r + 1'b1;
    end
  end

  `QOIENC_CHECK(a_pos_in_entry, !head_valid || ((head.count != '0) && (pos_r < head.count)), "byte position outside the head entry")

endmodule

FILE: hdl/qoi_pixel_encoder.sv
// Channel   Direction  Handshake      Content
// in_px     sink       valid/ready    red, green, blue, alpha, last_pixel
// out_byte  source     valid/ready    code_byte, last_of_pixel
// cfg (APB) slave      psel/penable   channel_count at byte address 0
//
// A pixel is taken whenever the classifier stage is empty or drains in that cycle. Its
// first byte passes the classifier stage register and the queue before it is offered
// on out_byte. The byte-wide output sets the sustained rate: a pixel yields up to six
// bytes (four for an RGB literal, five for RGBA), and a repeat pixel may yield none.
// rst_n is synchronous and active low; it restores the previous pixel, clears the run
// and marks every colour index entry empty at once. The queue absorbs output stalls.
module qoi_pixel_encoder #(
  parameter int unsigned QUEUE_DEPTH = qoienc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  qoienc_pix_if.sink                        in_px,
  qoienc_byte_if.source                     out_byte,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qoienc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [qoienc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [qoienc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                              pready
);
  import qoienc_pkg::*;

  logic [CH_W-1:0] ch_r;
  logic            cfg_wr;
  logic [0:0]      reg_idx;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;

  // The register file holds only the channel count. Registers are 32-bit words, so
  // the word index sits above the two byte-offset bits.
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_IDX_CHANNEL_COUNT) ?
                   {{(CFG_DATA_W - CH_W){1'b0}}, ch_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= CH_RGBA;
    end else if (cfg_wr && (reg_idx == REG_IDX_CHANNEL_COUNT)) begin
      ch_r <= pwdata[CH_W-1:0];
    end
  end

  // The front end compares each pixel against the previous one and the colour index,
  // updates that state and hands a complete list of bytes to the queue.
  qoienc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .channel_count (ch_r),
    .pix           (in_px),
    .cmd           (front_cmd),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready)
  );

  qoienc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cmd   (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_cmd   (head_cmd),
    .rd_valid (head_valid),
    .rd_pop   (head_pop)
  );

  // The back end serialises each entry, flagging the final byte of the pixel.
  qoienc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_cmd),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .ob         (out_byte)
  );

endmodule
